// ===== src/jac_pkg.sv =====
// Shared types, constants and helpers for the joystick axis conditioner.
package jac_pkg;

  localparam int RAW_W       = 12;
  localparam int FRAC_W      = 8;
  localparam int SMOOTH_W    = RAW_W + FRAC_W;
  localparam int Q8_W        = 9;
  localparam int Q8_ONE      = 256;
  localparam int DB_W        = 11;
  localparam int LIMIT_W     = 15;
  localparam int VAL_W       = LIMIT_W + 1;
  localparam int CFG_W       = 15;
  localparam int REG_IDX_W   = 2;

  // power of two
  localparam int CAL_SAMPLES = 64;
  localparam int CAL_LOG2    = $clog2(CAL_SAMPLES);
  localparam int SUM_W       = RAW_W + CAL_LOG2;
  localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);

  // power of two
  localparam int FULL_SCALE  = 2048;
  localparam int FS_LOG2     = $clog2(FULL_SCALE);
  localparam int MAG_W       = FS_LOG2 + 1;

  localparam int LANE_STAGES = 8;

  localparam logic [DB_W-1:0]    DEADBAND_RST     = DB_W'(0);
  localparam logic [Q8_W-1:0]    FILTER_W_RST     = Q8_W'(256);
  localparam logic [Q8_W-1:0]    EXPO_W_RST       = Q8_W'(0);
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = LIMIT_W'(1000);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEADBAND      = 2'd0,
    REG_FILTER_WEIGHT = 2'd1,
    REG_EXPO_WEIGHT   = 2'd2,
    REG_OUTPUT_LIMIT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             switch_level;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;
    logic                    switch_pressed;
    logic                    calibrated;
  } out_t;

  typedef struct packed {
    logic [DB_W-1:0]    deadband;
    logic [Q8_W-1:0]    filter_weight;
    logic [Q8_W-1:0]    expo_weight;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic cal_add;
    logic cal_last;
  } lane_ctl_t;

  function automatic logic [Q8_W-1:0] sat_q8(input logic [Q8_W-1:0] v);
    return (v > Q8_W'(Q8_ONE)) ? Q8_W'(Q8_ONE) : v;
  endfunction

endpackage

// ===== src/jac_lane.sv =====
// One axis lane: calibration sum, smoothing filter, deadband, expo curve and scaling.
module jac_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  jac_pkg::lane_ctl_t                    ctl,
  input  logic [jac_pkg::RAW_W-1:0]             raw,
  input  jac_pkg::cfg_t                         cfg,
  output logic signed [jac_pkg::VAL_W-1:0]      value,
  output logic                                  done
);

  localparam int P_NEW_W = jac_pkg::Q8_W + jac_pkg::RAW_W;
  localparam int P_OLD_W = jac_pkg::Q8_W + jac_pkg::SMOOTH_W;
  localparam int ACC_W   = P_OLD_W + 1;
  localparam int M2_W    = 2 * jac_pkg::MAG_W;
  localparam int M3_W    = 3 * jac_pkg::MAG_W;
  localparam int LIN_W   = jac_pkg::Q8_W + jac_pkg::MAG_W;
  localparam int CUB_W   = jac_pkg::Q8_W + M3_W;
  localparam int TOT_W   = CUB_W + 1;
  localparam int EXP_SH  = 2 * jac_pkg::FS_LOG2 + jac_pkg::FRAC_W;
  localparam int SC_W    = jac_pkg::MAG_W + jac_pkg::LIMIT_W;

  logic [jac_pkg::LANE_STAGES-1:0]  vld;

  logic [jac_pkg::SUM_W-1:0]        sum;
  logic [jac_pkg::RAW_W-1:0]        center;
  logic [jac_pkg::SMOOTH_W-1:0]     smooth;

  logic [P_NEW_W-1:0]               p_new;
  logic [P_OLD_W-1:0]               p_old;
  logic                             neg3, neg4, neg5, neg6, neg7, neg8;
  logic [jac_pkg::MAG_W-1:0]        m3, m4;
  logic [M2_W-1:0]                  m2;
  logic [LIN_W-1:0]                 lin4, lin5, lin6;
  logic [M3_W-1:0]                  cube;
  logic [CUB_W-1:0]                 cub;
  logic [jac_pkg::MAG_W-1:0]        expo;
  logic [jac_pkg::LIMIT_W-1:0]      sc;

  logic [jac_pkg::SUM_W-1:0]        sum_add;
  logic [jac_pkg::Q8_W-1:0]         w_inv;
  logic [jac_pkg::Q8_W-1:0]         e_inv;
  logic [ACC_W-1:0]                 acc;
  logic [jac_pkg::SMOOTH_W-1:0]     smooth_filt;
  logic [jac_pkg::RAW_W:0]          dev;
  logic [jac_pkg::RAW_W:0]          dev_neg;
  logic [jac_pkg::RAW_W-1:0]        mag;
  logic [jac_pkg::MAG_W-1:0]        m_sel;
  logic [TOT_W-1:0]                 tot;
  logic [SC_W-1:0]                  prod;
  logic [jac_pkg::VAL_W-1:0]        sc_ext;

  always_comb begin
    sum_add     = sum + jac_pkg::SUM_W'(raw);
    w_inv       = jac_pkg::Q8_W'(jac_pkg::Q8_ONE) - cfg.filter_weight;
    e_inv       = jac_pkg::Q8_W'(jac_pkg::Q8_ONE) - cfg.expo_weight;
    acc         = ACC_W'({p_new, {jac_pkg::FRAC_W{1'b0}}}) + ACC_W'(p_old);
    smooth_filt = acc[jac_pkg::FRAC_W +: jac_pkg::SMOOTH_W];
    dev         = {1'b0, smooth[jac_pkg::SMOOTH_W-1:jac_pkg::FRAC_W]} - {1'b0, center};
    dev_neg     = -dev;
    mag         = dev[jac_pkg::RAW_W] ? dev_neg[jac_pkg::RAW_W-1:0] : dev[jac_pkg::RAW_W-1:0];
    if (mag <= jac_pkg::RAW_W'(cfg.deadband)) begin
      m_sel = '0;
    end else if (mag > jac_pkg::RAW_W'(jac_pkg::FULL_SCALE)) begin
      m_sel = jac_pkg::MAG_W'(jac_pkg::FULL_SCALE);
    end else begin
      m_sel = mag[jac_pkg::MAG_W-1:0];
    end
    tot    = (TOT_W'(lin6) << (2 * jac_pkg::FS_LOG2)) + TOT_W'(cub);
    prod   = SC_W'(expo) * SC_W'(cfg.output_limit);
    sc_ext = {1'b0, sc};
    value  = neg8 ? -sc_ext : sc_ext;
    done   = vld[jac_pkg::LANE_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[jac_pkg::LANE_STAGES-2:0], ctl.start};
    end
  end

  // calibration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      center <= '0;
      smooth <= '0;
    end else if (ctl.cal_add) begin
      sum <= sum_add;
      if (ctl.cal_last) begin
        center <= sum_add[jac_pkg::CAL_LOG2 +: jac_pkg::RAW_W];
        smooth <= {sum_add[jac_pkg::CAL_LOG2 +: jac_pkg::RAW_W], {jac_pkg::FRAC_W{1'b0}}};
      end
    end else if (vld[0]) begin
      smooth <= smooth_filt;
    end
  end

  always_ff @(posedge clk) begin
    p_new <= P_NEW_W'(cfg.filter_weight) * P_NEW_W'(raw);
    p_old <= P_OLD_W'(w_inv) * P_OLD_W'(smooth);
    neg3  <= dev[jac_pkg::RAW_W];
    m3    <= m_sel;
    neg4  <= neg3;
    m4    <= m3;
    m2    <= M2_W'(m3) * M2_W'(m3);
    lin4  <= LIN_W'(e_inv) * LIN_W'(m3);
    neg5  <= neg4;
    lin5  <= lin4;
    cube  <= M3_W'(m2) * M3_W'(m4);
    neg6  <= neg5;
    lin6  <= lin5;
    cub   <= CUB_W'(cfg.expo_weight) * CUB_W'(cube);
    neg7  <= neg6;
    expo  <= tot[EXP_SH +: jac_pkg::MAG_W];
    if (vld[jac_pkg::LANE_STAGES-2]) begin
      neg8 <= neg7;
      sc   <= prod[jac_pkg::FS_LOG2 +: jac_pkg::LIMIT_W];
    end
  end

endmodule

// ===== src/joystick_axis_conditioner.sv =====
// Top level: configuration registers, calibration count, control and result merge.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one request per sample pair:
//   raw_x, raw_y and the switch level. Output channel (out_valid/out_ready/out_data)
//   returns exactly one result per request, in order.
//   The first CAL_SAMPLES requests build the per-axis baselines; their results carry
//   zero deflection and calibrated = 0. Later requests run both axis lanes side by
//   side (filter, deadband, expo, scaling) and the merge stage packs both lanes and
//   the switch state into the output register.
//   After accept, a calibration request goes straight to the done state, while a later
//   request first runs through the eight-stage lane pipeline. One request is in flight at
//   a time, so a new request is taken only once the previous result has left the lanes.
//   The output register lets the next request be accepted while a result waits.
//   If the receiver stalls, the finished result stays in the output register and the
//   next one waits in the lanes until the register frees up.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
//   make them while no request is in flight, as the block itself does not enforce this.
//   Reset (rst, synchronous) restores register defaults, restarts calibration and
//   drops any pending result.
module joystick_axis_conditioner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  jac_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output jac_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [jac_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [jac_pkg::CFG_W-1:0]         cfg_data
);

  jac_pkg::state_t                  state, state_next;
  logic [jac_pkg::DB_W-1:0]         deadband;
  logic [jac_pkg::Q8_W-1:0]         filter_weight;
  logic [jac_pkg::Q8_W-1:0]         expo_weight;
  logic [jac_pkg::LIMIT_W-1:0]      output_limit;
  logic [jac_pkg::CNT_W-1:0]        cal_count;
  logic                             cal_done;
  logic                             item_cal;
  logic                             item_sw;

  logic                             accept;
  logic                             load_out;
  jac_pkg::cfg_t                    cfg;
  jac_pkg::lane_ctl_t               ctl;
  logic signed [jac_pkg::VAL_W-1:0] value_x, value_y;
  logic                             done_x, done_y;

  assign accept = in_valid && in_ready;

  always_comb begin
    cfg.deadband      = deadband;
    cfg.filter_weight = jac_pkg::sat_q8(filter_weight);
    cfg.expo_weight   = jac_pkg::sat_q8(expo_weight);
    cfg.output_limit  = output_limit;
    ctl.start         = accept && cal_done;
    ctl.cal_add       = accept && !cal_done;
    ctl.cal_last      = (cal_count == jac_pkg::CNT_W'(jac_pkg::CAL_SAMPLES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband      <= jac_pkg::DEADBAND_RST;
      filter_weight <= jac_pkg::FILTER_W_RST;
      expo_weight   <= jac_pkg::EXPO_W_RST;
      output_limit  <= jac_pkg::OUTPUT_LIMIT_RST;
    end else if (cfg_we) begin
      case (jac_pkg::reg_idx_t'(cfg_index))
        jac_pkg::REG_DEADBAND:      deadband      <= cfg_data[jac_pkg::DB_W-1:0];
        jac_pkg::REG_FILTER_WEIGHT: filter_weight <= cfg_data[jac_pkg::Q8_W-1:0];
        jac_pkg::REG_EXPO_WEIGHT:   expo_weight   <= cfg_data[jac_pkg::Q8_W-1:0];
        jac_pkg::REG_OUTPUT_LIMIT:  output_limit  <= cfg_data[jac_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count <= '0;
      cal_done  <= 1'b0;
    end else if (ctl.cal_add) begin
      cal_count <= cal_count + jac_pkg::CNT_W'(1);
      if (ctl.cal_last) begin
        cal_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cal <= cal_done;
      item_sw  <= in_data.switch_level;
    end
  end

  jac_lane u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .raw   (in_data.raw_x),
    .cfg   (cfg),
    .value (value_x),
    .done  (done_x)
  );

  jac_lane u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .raw   (in_data.raw_y),
    .cfg   (cfg),
    .value (value_y),
    .done  (done_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      jac_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = cal_done ? jac_pkg::ST_RUN : jac_pkg::ST_DONE;
        end
      end
      jac_pkg::ST_RUN: begin
        if (done_x && done_y) begin
          state_next = jac_pkg::ST_DONE;
        end
      end
      jac_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = jac_pkg::ST_IDLE;
        end
      end
      default: state_next = jac_pkg::ST_IDLE;
    endcase
  end

  // merge stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.x_value        <= item_cal ? value_x : '0;
      out_data.y_value        <= item_cal ? value_y : '0;
      out_data.switch_pressed <= !item_sw;
      out_data.calibrated     <= item_cal;
    end
  end

endmodule

// ===== src/jac_checker.sv =====
// Port-level checks for the joystick axis conditioner, bound to the top level.
module jac_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input jac_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.calibrated |-> out_data.x_value == '0 && out_data.y_value == '0)
    else $error("nonzero deflection before calibration");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.x_value != 16'sh8000 && out_data.y_value != 16'sh8000)
    else $error("deflection out of range");

endmodule

bind joystick_axis_conditioner jac_checker u_jac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/joystick_axis_conditioner_tb.sv =====
// Self-checking testbench for the joystick axis conditioner: calibration, filter, curve.
`timescale 1ns / 1ps

module joystick_axis_conditioner_tb;
  import jac_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES = 12;
  localparam int PHASE_SAMPLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  in_t sample_q[$];
  out_t deflection_q[$];
  logic in_taken = 1'b0;
  bit quiet = 1'b0;
  int mismatch_count = 0;
  int result_count = 0;
  int stall_cycles = 0;

  // shadow of the register file
  logic [DB_W-1:0] cfg_deadband = DEADBAND_RST;
  logic [Q8_W-1:0] cfg_fweight = FILTER_W_RST;
  logic [Q8_W-1:0] cfg_eweight = EXPO_W_RST;
  logic [LIMIT_W-1:0] cfg_limit = OUTPUT_LIMIT_RST;

  // shadow of the calibration and filter state
  int unsigned cal_cnt = 0;
  int unsigned sum_x = 0;
  int unsigned sum_y = 0;
  logic [RAW_W-1:0] ctr_x = '0;
  logic [RAW_W-1:0] ctr_y = '0;
  logic [SMOOTH_W-1:0] sm_x = '0;
  logic [SMOOTH_W-1:0] sm_y = '0;
  bit cal_done = 1'b0;

  joystick_axis_conditioner DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [SMOOTH_W-1:0] filter_axis(input logic [SMOOTH_W-1:0] sm,
                                                      input logic [RAW_W-1:0] raw);
    longint unsigned w;
    longint unsigned acc;
    w = (cfg_fweight > 9'd256) ? 64'd256 : 64'(cfg_fweight);
    acc = w * 64'({raw, 8'h00}) + (64'd256 - w) * 64'(sm);
    return SMOOTH_W'(acc >> 8);
  endfunction

  function automatic logic [VAL_W-1:0] shape_axis(input logic [SMOOTH_W-1:0] sm,
                                                  input logic [RAW_W-1:0] ctr);
    int dev;
    bit neg;
    longint unsigned m, e, f, expo, scaled;
    dev = int'({1'b0, sm[SMOOTH_W-1:FRAC_W]}) - int'({1'b0, ctr});
    neg = dev < 0;
    m = neg ? 64'(-dev) : 64'(dev);
    f = 64'(FULL_SCALE);
    e = (cfg_eweight > 9'd256) ? 64'd256 : 64'(cfg_eweight);
    if (m <= 64'(cfg_deadband)) m = 0;
    if (m > f) m = f;
    expo = ((64'd256 - e) * m * f * f + e * m * m * m) / (64'd256 * f * f);
    scaled = expo * 64'(cfg_limit) / f;
    if (neg) scaled = 64'd0 - scaled;
    return VAL_W'(scaled);
  endfunction

  task automatic condition_sample(input in_t s);
    out_t r;
    r = '0;
    r.switch_pressed = ~s.switch_level;
    if (!cal_done) begin
      sum_x += s.raw_x;
      sum_y += s.raw_y;
      cal_cnt++;
      if (cal_cnt >= CAL_SAMPLES) begin
        ctr_x = RAW_W'(sum_x / CAL_SAMPLES);
        ctr_y = RAW_W'(sum_y / CAL_SAMPLES);
        sm_x = {ctr_x, 8'h00};
        sm_y = {ctr_y, 8'h00};
        cal_done = 1'b1;
      end
    end else begin
      sm_x = filter_axis(sm_x, s.raw_x);
      sm_y = filter_axis(sm_y, s.raw_y);
      r.x_value = shape_axis(sm_x, ctr_x);
      r.y_value = shape_axis(sm_y, ctr_y);
      r.calibrated = 1'b1;
    end
    deflection_q.push_back(r);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    result_count++;
    if (deflection_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d with no request pending: x=%0d y=%0d sw=%b cal=%b",
                 result_count, got.x_value, got.y_value, got.switch_pressed, got.calibrated);
    end else begin
      want = deflection_q.pop_front();
      if (got.x_value !== want.x_value || got.y_value !== want.y_value ||
          got.switch_pressed !== want.switch_pressed || got.calibrated !== want.calibrated) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: expected x=%0d y=%0d sw=%b cal=%b, got x=%0d y=%0d sw=%b cal=%b",
                   result_count, want.x_value, want.y_value, want.switch_pressed,
                   want.calibrated, got.x_value, got.y_value, got.switch_pressed,
                   got.calibrated);
      end
    end
  endtask

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) condition_sample(in_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no progress for %0d cycles", stall_cycles);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
        in_valid <= 1'b1;
        in_data <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (quiet || $urandom_range(0, 99) >= 12);
  end

  function automatic logic [RAW_W-1:0] clamp_raw(input int v);
    if (v < 0) return '0;
    if (v > 4095) return RAW_W'(4095);
    return RAW_W'(v);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(input int ctr);
    case ($urandom_range(0, 7))
      0, 1: return RAW_W'($urandom_range(0, 4095));
      2: return $urandom_range(0, 1) ? RAW_W'(4095) : RAW_W'(0);
      3: return clamp_raw(ctr + int'($urandom_range(0, 40)) - 20);
      default: return clamp_raw(ctr + int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  task automatic push_sample(input int x, input int y, input bit sw);
    in_t s;
    s.raw_x = clamp_raw(x);
    s.raw_y = clamp_raw(y);
    s.switch_level = sw;
    sample_q.push_back(s);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_DEADBAND: cfg_deadband = data[DB_W-1:0];
      REG_FILTER_WEIGHT: cfg_fweight = data[Q8_W-1:0];
      REG_EXPO_WEIGHT: cfg_eweight = data[Q8_W-1:0];
      REG_OUTPUT_LIMIT: cfg_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || deflection_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int cal_ctr;
    int cx, cy;
    logic [CFG_W-1:0] db_d, fw_d, ew_d, lim_d;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // calibration: corners first, then samples around a random rest position
    cal_ctr = $urandom_range(800, 3300);
    push_sample(0, 4095, 0);
    push_sample(4095, 0, 1);
    push_sample(0, 0, 1);
    push_sample(4095, 4095, 0);
    for (int i = 4; i < CAL_SAMPLES; i++)
      push_sample(cal_ctr + int'($urandom_range(0, 600)) - 300,
                  cal_ctr + int'($urandom_range(0, 600)) - 300, $urandom_range(0, 1));
    drain();
    cx = ctr_x;
    cy = ctr_y;

    // reset settings: centered, negative deviation rounding to zero, full travel
    push_sample(cx, cy, 1);
    push_sample(cx - 1, cy + 1, 0);
    push_sample(0, 4095, 1);
    push_sample(4095, 0, 0);
    push_sample(cx + 2048, cy - 2048, 1);
    drain();

    // deadband edge, with junk above the field
    write_reg(REG_DEADBAND, {4'hF, 11'd100});
    end_writes();
    push_sample(cx + 100, cy - 100, 0);
    push_sample(cx + 101, cy - 101, 1);
    push_sample(cx - 100, cy + 101, 0);
    drain();

    write_reg(REG_EXPO_WEIGHT, CFG_W'(256));
    write_reg(REG_OUTPUT_LIMIT, CFG_W'(32767));
    end_writes();
    push_sample(4095, 0, 1);
    push_sample(cx + 1024, cy - 1024, 0);
    push_sample(cx - 600, cy + 600, 1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          db_d = CFG_W'(DEADBAND_RST);
          fw_d = CFG_W'(FILTER_W_RST);
          ew_d = CFG_W'(EXPO_W_RST);
          lim_d = CFG_W'(OUTPUT_LIMIT_RST);
        end
        1: begin
          db_d = 15'h7FFF;
          fw_d = '0;
          ew_d = CFG_W'(256);
          lim_d = CFG_W'(32767);
        end
        2: begin
          db_d = '0;
          fw_d = 15'h01FF;
          ew_d = 15'h7FFF;
          lim_d = CFG_W'(32767);
        end
        3: begin
          db_d = CFG_W'(5);
          fw_d = CFG_W'(1);
          ew_d = CFG_W'(128);
          lim_d = '0;
        end
        default: begin
          db_d = {4'($urandom_range(0, 15)),
                  11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, 300))};
          case ($urandom_range(0, 9))
            0: fw_d = {6'($urandom_range(0, 63)), 9'($urandom_range(257, 511))};
            1: fw_d = {6'($urandom_range(0, 63)), 9'd0};
            default: fw_d = {6'($urandom_range(0, 63)), 9'($urandom_range(8, 256))};
          endcase
          ew_d = {6'($urandom_range(0, 63)),
                  9'(($urandom_range(0, 7) == 0) ? $urandom_range(257, 511)
                                                 : $urandom_range(0, 256))};
          lim_d = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 32767))
                                              : CFG_W'($urandom_range(500, 4000));
        end
      endcase
      write_reg(REG_DEADBAND, db_d);
      write_reg(REG_FILTER_WEIGHT, fw_d);
      write_reg(REG_EXPO_WEIGHT, ew_d);
      write_reg(REG_OUTPUT_LIMIT, lim_d);
      end_writes();
      quiet = (ph == 5 || ph == 6);
      for (int i = 0; i < PHASE_SAMPLES; i++)
        push_sample(pick_raw(cx), pick_raw(cy), $urandom_range(0, 1));
      drain();
    end
    quiet = 1'b0;

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
